// ----- src/ppbs_pkg.sv -----
// Shared types and constants for the priority burst scheduler.
// No dependencies; used by the cell, the top level and the checker.
`timescale 1ns / 1ps
`default_nettype none

package ppbs_pkg;

    localparam int unsigned MAX_TASKS_DEF  = 16;
    localparam int unsigned MAX_BURSTS_DEF = 64;

    localparam int unsigned OP_W    = 2;
    localparam int unsigned SLOT_W  = 4;
    localparam int unsigned ID_W    = 16;
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned BURST_W = 16;
    localparam int unsigned COUNT_W = 5;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD   = 2'd0,
        OP_APPEND = 2'd1,
        OP_TICK   = 2'd2,
        OP_NOP    = 2'd3
    } t_op;

    // Priority and completion signals passed from cell to cell.
    typedef struct packed {
        logic taken;
        logic all_done;
    } t_chain;

endpackage

`default_nettype wire

// ----- src/ppbs_burst_mem.sv -----
// Burst length store: one write port, two registered read ports.
// Depends on nothing beyond its parameters.
`timescale 1ns / 1ps
`default_nettype none

module ppbs_burst_mem #(
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned AW    = 10,
    parameter int unsigned DW    = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr0,
    input  wire logic [AW-1:0] i_raddr1,
    output logic      [DW-1:0] o_rdata0,
    output logic      [DW-1:0] o_rdata1
);

    logic [DW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata0 <= r_mem[i_raddr0];
            o_rdata1 <= r_mem[i_raddr1];
        end
    end

endmodule

`default_nettype wire

// ----- src/ppbs_cell.sv -----
// One task slot: header, burst fill/position, ready time and done flag.
// Depends on ppbs_pkg (t_chain, widths).
`timescale 1ns / 1ps
`default_nettype none

module ppbs_cell #(
    parameter int unsigned IDX = 0,
    parameter int unsigned SW  = 4,
    parameter int unsigned FW  = 7,
    parameter int unsigned NW  = 5,
    parameter int unsigned MB  = 64
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_load,
    input  wire logic                         i_append,
    input  wire logic [ppbs_pkg::SLOT_W-1:0]  i_slot,
    input  wire logic [ppbs_pkg::ID_W-1:0]    i_task_id,
    input  wire logic [ppbs_pkg::TIME_W-1:0]  i_arrival,
    input  wire logic                         i_commit,
    input  wire logic [SW-1:0]                i_sel,
    input  wire logic                         i_upd_fin,
    input  wire logic                         i_upd_io,
    input  wire logic [ppbs_pkg::TIME_W-1:0]  i_upd_ready,
    input  wire logic [FW-1:0]                i_upd_pos,
    input  wire logic [ppbs_pkg::TIME_W-1:0]  i_now,
    input  wire logic [NW-1:0]                i_active_n,
    input  wire ppbs_pkg::t_chain             i_chain,
    output ppbs_pkg::t_chain                  o_chain,
    output logic                              o_grant,
    output logic [ppbs_pkg::ID_W-1:0]         o_id,
    output logic [ppbs_pkg::TIME_W-1:0]       o_arrival,
    output logic [FW-1:0]                     o_pos,
    output logic [FW-1:0]                     o_fill,
    output logic [FW-1:0]                     o_fill_slot
);
    import ppbs_pkg::*;

    logic [ID_W-1:0]   r_id;
    logic [TIME_W-1:0] r_ready;
    logic [TIME_W-1:0] r_arrival;
    logic [FW-1:0]     r_fill;
    logic [FW-1:0]     r_pos;
    logic              r_done;

    logic w_match, w_mine, w_active, w_elig, w_done_after;

    assign w_match  = (int'(i_slot) == IDX);
    assign w_mine   = i_commit && (int'(i_sel) == IDX);
    assign w_active = (int'(i_active_n) > IDX);
    assign w_elig   = w_active && !r_done && (r_ready <= i_now);
    assign w_done_after = r_done || (w_mine && i_upd_fin);

    assign o_grant          = w_elig && !i_chain.taken;
    assign o_chain.taken    = i_chain.taken || w_elig;
    assign o_chain.all_done = i_chain.all_done && (w_done_after || !w_active);

    assign o_id        = o_grant ? r_id      : '0;
    assign o_arrival   = o_grant ? r_arrival : '0;
    assign o_pos       = o_grant ? r_pos     : '0;
    assign o_fill      = o_grant ? r_fill    : '0;
    assign o_fill_slot = w_match ? r_fill    : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_id      <= '0;
            r_ready   <= '0;
            r_arrival <= '0;
            r_fill    <= '0;
            r_pos     <= '0;
            r_done    <= 1'b0;
        end else if (i_load && w_match) begin
            r_id      <= i_task_id;
            r_ready   <= i_arrival;
            r_arrival <= i_arrival;
            r_fill    <= '0;
            r_pos     <= '0;
            r_done    <= 1'b0;
        end else if (i_append && w_match) begin
            if (int'(r_fill) < MB) begin
                r_fill <= FW'(int'(r_fill) + 1);
            end
        end else if (w_mine) begin
            if (i_upd_fin) begin
                r_done <= 1'b1;
            end else if (i_upd_io) begin
                r_ready <= i_upd_ready;
                r_pos   <= i_upd_pos;
            end
        end
    end

endmodule

`default_nettype wire

// ----- src/preemptive_priority_burst_scheduler_unit.sv -----
// Top level of the preemptive priority burst scheduler: a row of slot cells,
// the burst store and the tick sequencer. Depends on ppbs_pkg, ppbs_cell,
// ppbs_burst_mem.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  cfg     | i_cfg_we, i_cfg_data                      | in
//  in      | i_in_valid/o_in_ready, i_op..i_burst_len  | in
//  out     | o_out_valid/i_out_ready, o_now..o_all_done| out
//
// Load and append transfers are applied as they are accepted. A tick first
// walks the cell row for the winner and reads its CPU and IO bursts; the
// execute state then updates the burst and the cell and loads the output
// register. The execute state holds while a previous result is still not
// taken; the input side stays open at all other times. Reset is synchronous
// and clears every slot; burst entries are only used below their fill count.
`timescale 1ns / 1ps
`default_nettype none

module preemptive_priority_burst_scheduler_unit #(
    parameter int unsigned MAX_TASKS  = ppbs_pkg::MAX_TASKS_DEF,
    parameter int unsigned MAX_BURSTS = ppbs_pkg::MAX_BURSTS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [ppbs_pkg::COUNT_W-1:0] i_cfg_data,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic [ppbs_pkg::OP_W-1:0]    i_op,
    input  wire logic [ppbs_pkg::SLOT_W-1:0]  i_slot,
    input  wire logic [ppbs_pkg::ID_W-1:0]    i_task_id,
    input  wire logic [ppbs_pkg::TIME_W-1:0]  i_arrival,
    input  wire logic [ppbs_pkg::BURST_W-1:0] i_burst_len,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic [ppbs_pkg::TIME_W-1:0]       o_now,
    output logic                              o_ran,
    output logic [ppbs_pkg::ID_W-1:0]         o_run_id,
    output logic                              o_finished,
    output logic                              o_to_io,
    output logic [ppbs_pkg::TIME_W-1:0]       o_turnaround,
    output logic                              o_all_done
);
    import ppbs_pkg::*;

    localparam int unsigned SW    = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int unsigned FW    = $clog2(MAX_BURSTS + 1);
    localparam int unsigned NW    = $clog2(MAX_TASKS + 1);
    localparam int unsigned DEPTH = MAX_TASKS * MAX_BURSTS;
    localparam int unsigned AW    = $clog2(DEPTH);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state, n_state;

    logic [COUNT_W-1:0] r_task_count;
    logic [TIME_W-1:0]  r_clock;

    // Tick context captured at the pick cycle.
    logic              r_hit;
    logic [SW-1:0]     r_sel;
    logic [ID_W-1:0]   r_id;
    logic [TIME_W-1:0] r_arrival;
    logic [FW-1:0]     r_pos;
    logic [FW-1:0]     r_fill;
    logic [AW-1:0]     r_addr;

    logic w_in_xfer, w_tick, w_load, w_append, w_commit, w_out_free;
    logic [NW-1:0] w_active_n;

    t_chain          w_chain [MAX_TASKS+1];
    logic            w_grant [MAX_TASKS];
    logic [ID_W-1:0]   w_c_id      [MAX_TASKS];
    logic [TIME_W-1:0] w_c_arrival [MAX_TASKS];
    logic [FW-1:0]     w_c_pos     [MAX_TASKS];
    logic [FW-1:0]     w_c_fill    [MAX_TASKS];
    logic [FW-1:0]     w_c_fslot   [MAX_TASKS];

    logic              w_hit;
    logic [SW-1:0]     w_sel;
    logic [ID_W-1:0]   w_id;
    logic [TIME_W-1:0] w_arr;
    logic [FW-1:0]     w_pos, w_fill, w_fill_slot;

    logic               w_mem_we;
    logic [AW-1:0]      w_mem_waddr;
    logic [BURST_W-1:0] w_mem_wdata;
    logic [AW-1:0]      w_raddr0, w_raddr1;
    logic [BURST_W-1:0] w_rd_cpu, w_rd_io;

    logic               w_has_cpu, w_over, w_fin, w_io;
    logic [BURST_W-1:0] w_dec;
    logic [TIME_W-1:0]  w_new_ready;
    logic [FW-1:0]      w_new_pos;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_xfer  = i_in_valid && o_in_ready;
    assign w_load     = w_in_xfer && (t_op'(i_op) == OP_LOAD);
    assign w_append   = w_in_xfer && (t_op'(i_op) == OP_APPEND);
    assign w_tick     = w_in_xfer && (t_op'(i_op) == OP_TICK);
    assign w_out_free = !o_out_valid || i_out_ready;
    assign w_commit   = (r_state == S_EXEC) && w_out_free;

    // A task count past the table size behaves as the table size.
    assign w_active_n = (int'(r_task_count) > MAX_TASKS) ? NW'(MAX_TASKS)
                                                         : NW'(r_task_count);

    // Cell row: the priority token runs from slot 0 upward.
    assign w_chain[0].taken    = 1'b0;
    assign w_chain[0].all_done = 1'b1;

    for (genvar k = 0; k < MAX_TASKS; k++) begin : g_cell
        ppbs_cell #(
            .IDX (k),
            .SW  (SW),
            .FW  (FW),
            .NW  (NW),
            .MB  (MAX_BURSTS)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_load      (w_load),
            .i_append    (w_append),
            .i_slot      (i_slot),
            .i_task_id   (i_task_id),
            .i_arrival   (i_arrival),
            .i_commit    (w_commit && r_hit),
            .i_sel       (r_sel),
            .i_upd_fin   (w_fin),
            .i_upd_io    (w_io),
            .i_upd_ready (w_new_ready),
            .i_upd_pos   (w_new_pos),
            .i_now       (r_clock),
            .i_active_n  (w_active_n),
            .i_chain     (w_chain[k]),
            .o_chain     (w_chain[k+1]),
            .o_grant     (w_grant[k]),
            .o_id        (w_c_id[k]),
            .o_arrival   (w_c_arrival[k]),
            .o_pos       (w_c_pos[k]),
            .o_fill      (w_c_fill[k]),
            .o_fill_slot (w_c_fslot[k])
        );
    end

    // Cell outputs are zero unless granted/addressed, so OR collects them.
    always_comb begin
        w_sel       = '0;
        w_id        = '0;
        w_arr       = '0;
        w_pos       = '0;
        w_fill      = '0;
        w_fill_slot = '0;
        for (int k = 0; k < MAX_TASKS; k++) begin
            w_sel       = w_sel | (w_grant[k] ? SW'(k) : '0);
            w_id        = w_id | w_c_id[k];
            w_arr       = w_arr | w_c_arrival[k];
            w_pos       = w_pos | w_c_pos[k];
            w_fill      = w_fill | w_c_fill[k];
            w_fill_slot = w_fill_slot | w_c_fslot[k];
        end
    end
    assign w_hit = w_chain[MAX_TASKS].taken;

    // Current CPU burst and the IO burst after it; the IO read is only used
    // when a later CPU burst exists, so its address wrap does no harm.
    assign w_raddr0 = AW'(int'(w_sel) * MAX_BURSTS + int'(w_pos));
    assign w_raddr1 = AW'(int'(w_sel) * MAX_BURSTS + int'(w_pos) + 1);

    // Tick evaluation in the execute state.
    assign w_has_cpu   = (r_pos < r_fill);
    assign w_dec       = w_rd_cpu - BURST_W'(1);
    assign w_over      = !w_has_cpu || (w_dec == '0);
    assign w_fin       = w_over && (!w_has_cpu || (int'(r_pos) + 2 >= int'(r_fill)));
    assign w_io        = w_over && !w_fin;
    assign w_new_ready = r_clock + TIME_W'(w_rd_io);
    assign w_new_pos   = FW'(int'(r_pos) + 2);

    // Single write port: appends in the idle state, decrements at commit.
    always_comb begin
        w_mem_we    = 1'b0;
        w_mem_waddr = r_addr;
        w_mem_wdata = w_dec;
        if (w_append && (int'(i_slot) < MAX_TASKS) && (int'(w_fill_slot) < MAX_BURSTS)) begin
            w_mem_we    = 1'b1;
            w_mem_waddr = AW'(int'(i_slot) * MAX_BURSTS + int'(w_fill_slot));
            w_mem_wdata = i_burst_len;
        end else if (w_commit && r_hit && w_has_cpu) begin
            w_mem_we = 1'b1;
        end
    end

    ppbs_burst_mem #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .DW    (BURST_W)
    ) u_mem (
        .i_clk    (i_clk),
        .i_we     (w_mem_we),
        .i_waddr  (w_mem_waddr),
        .i_wdata  (w_mem_wdata),
        .i_re     (w_tick),
        .i_raddr0 (w_raddr0),
        .i_raddr1 (w_raddr1),
        .o_rdata0 (w_rd_cpu),
        .o_rdata1 (w_rd_io)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_tick) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_task_count <= '0;
            r_clock      <= '0;
            o_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_task_count <= i_cfg_data;
            end
            if (w_commit) begin
                r_clock     <= r_clock + TIME_W'(1);
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    // Tick context and result payload.
    always_ff @(posedge i_clk) begin
        if (w_tick) begin
            r_hit     <= w_hit;
            r_sel     <= w_sel;
            r_id      <= w_id;
            r_arrival <= w_arr;
            r_pos     <= w_pos;
            r_fill    <= w_fill;
            r_addr    <= w_raddr0;
        end
        if (w_commit) begin
            o_now        <= r_clock;
            o_ran        <= r_hit;
            o_run_id     <= r_hit ? r_id : '0;
            o_finished   <= r_hit && w_fin;
            o_to_io      <= r_hit && w_io;
            o_turnaround <= (r_hit && w_fin) ? (r_clock - r_arrival) : '0;
            o_all_done   <= w_chain[MAX_TASKS].all_done;
        end
    end

endmodule

`default_nettype wire

// ----- src/ppbs_checker.sv -----
// Port-level checks for the scheduler, bound to the top level.
// Depends on ppbs_pkg widths only.
`timescale 1ns / 1ps
`default_nettype none

module ppbs_checker (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         o_out_valid,
    input wire logic                         i_out_ready,
    input wire logic [ppbs_pkg::TIME_W-1:0]  o_now,
    input wire logic                         o_ran,
    input wire logic [ppbs_pkg::ID_W-1:0]    o_run_id,
    input wire logic                         o_finished,
    input wire logic                         o_to_io,
    input wire logic [ppbs_pkg::TIME_W-1:0]  o_turnaround
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_now))
        else $error("result dropped while stalled");

    a_fin_ran: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_finished || o_to_io) |-> o_ran)
        else $error("completion or IO without a running task");

    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_finished && o_to_io))
        else $error("finished and IO entry together");

    a_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_ran |-> (o_run_id == '0) && (o_turnaround == '0))
        else $error("idle tick carries task data");

endmodule

bind preemptive_priority_burst_scheduler_unit ppbs_checker u_ppbs_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_now        (o_now),
    .o_ran        (o_ran),
    .o_run_id     (o_run_id),
    .o_finished   (o_finished),
    .o_to_io      (o_to_io),
    .o_turnaround (o_turnaround)
);

`default_nettype wire
